FILE: hdl/omni_wheel_speed_limiter_core_defines.svh
// Assertion macros for the omni wheel speed limiter
`ifndef OMNI_WHEEL_SPEED_LIMITER_CORE_DEFINES_SVH
`define OMNI_WHEEL_SPEED_LIMITER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OWSL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owsl same-cycle check failed");
`define OWSL_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owsl next-cycle check failed");
`else
`define OWSL_ASSERT_IMP(name, ante, cons)
`define OWSL_ASSERT_NXT(name, ante, cons)
`endif

`endif

FILE: hdl/owsl_pkg.sv
// Shared types and constants of the omni wheel speed limiter
package owsl_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int TW        = 48;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROBOT_R = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd4;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_MUL,
		ST_ROT_ADD,
		ST_WHL_MUL,
		ST_WHL_WR,
		ST_VCHK,
		ST_DIV,
		ST_SC_LO,
		ST_SC_HI,
		ST_SC_WR,
		ST_ACC_MUL,
		ST_ACC_LIM,
		ST_BMAX,
		ST_BCHK,
		ST_FIN
	} state_t;

endpackage

FILE: hdl/owsl_if.sv
// Command and result channel interfaces of the omni wheel speed limiter
interface owsl_cmd_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] rot_z;
	logic        [15:0] elapsed_time;

	modport source (output valid, opcode, vel_x, vel_y, rot_z, elapsed_time, input ready);
	modport sink   (input valid, opcode, vel_x, vel_y, rot_z, elapsed_time, output ready);
endinterface

interface owsl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] wheel_speed_0;
	logic signed [31:0] wheel_speed_1;
	logic signed [31:0] wheel_speed_2;
	logic signed [31:0] wheel_speed_3;
	logic               velocity_limited;
	logic               accel_limited;

	modport source (output valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		velocity_limited, accel_limited, input ready);
	modport sink   (input valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		velocity_limited, accel_limited, output ready);
endinterface

FILE: hdl/omni_wheel_speed_limiter_core.sv
// Omni wheel speed limiter: top level with shared multiplier and divider
// Set-target transaction: accepted while idle, no result.
// Tick transaction: four wheel speeds, then optional velocity and acceleration scaling, using
// one 36x24 multiplier and one 16-step divider.
// One transaction at a time; the result register lets a new transaction in while it waits.
// Asynchronous active-low reset clears control, limits, invert mask and the stored speeds.
`include "omni_wheel_speed_limiter_core_defines.svh"

module omni_wheel_speed_limiter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [owsl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owsl_pkg::CFG_DAT_W-1:0]    cfg_data,
	owsl_cmd_if.sink                          cmd,
	owsl_rsp_if.source                        rsp
);
	import owsl_pkg::*;

	state_t state_q, state_d;

	logic signed [31:0] maxv_q, maxa_q;
	logic        [17:0] rr_q;
	logic        [23:0] iwr_q;
	logic        [2:0]  invm_q;

	logic signed [31:0] tx_q, ty_q, trot_q;
	logic signed [31:0] last_q [4];
	logic signed [TW-1:0] t_q [4];
	logic        [15:0] dt_q;
	logic signed [34:0] r_q;
	logic        [1:0]  i_q;
	logic        [TW-1:0] amax_q, b_q;
	logic        [31:0] m_q;
	logic        acc_ph_q, vlim_q, alim_q;
	logic        [63:0] rem_q, dsh_q;
	logic        [15:0] quo_q;
	logic        [3:0]  cnt_q;
	logic        [39:0] lo_q;

	logic signed [35:0] mul_a;
	logic        [23:0] mul_b;
	logic signed [60:0] prod_q;

	logic out_valid_q;
	logic signed [31:0] ws_q [4];
	logic ovl_q, oal_q;

	logic accept, fin_load, div_ge, vel_over, last_wheel;
	logic signed [63:0] p64, rot_r, wheel_t;
	logic signed [35:0] lin_s;
	logic signed [TW-1:0] sc_v, sc_res, sc_new;
	logic        [TW-1:0] sc_mag, wt_mag;
	logic        [63:0] sc_sum;
	logic        [30:0] div_lim;
	logic        [TW-1:0] div_den;

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		if (v == 32'sh8000_0000)
			return 32'sh7FFF_FFFF;
		return -v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] v);
		if (v > TW'(64'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < -TW'(64'sh8000_0000))
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	assign accept   = cmd.valid && cmd.ready;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign last_wheel = (i_q == 2'd3);
	assign vel_over = !maxv_q[31] && (amax_q > TW'(maxv_q[30:0]));

	// shared datapath arithmetic
	always_comb begin
		p64     = {{3{prod_q[60]}}, prod_q};
		rot_r   = (p64 + 64'sd32768) >>> 16;
		wheel_t = (-p64 + 64'sd32768) >>> 16;
		wt_mag  = wheel_t[TW-1] ? TW'(-wheel_t) : wheel_t[TW-1:0];
		case (i_q)
			2'd0:    lin_s = 36'(ty_q);
			2'd1:    lin_s = 36'(tx_q);
			2'd2:    lin_s = -36'(ty_q);
			default: lin_s = -36'(tx_q);
		endcase
		lin_s   = lin_s + 36'(r_q);
		sc_v    = acc_ph_q ? (t_q[i_q] - TW'(last_q[i_q])) : t_q[i_q];
		sc_mag  = sc_v[TW-1] ? TW'(-sc_v) : sc_v;
		sc_sum  = ({24'd0, prod_q[39:0]} << 24) + {24'd0, lo_q};
		sc_res  = sc_v[TW-1] ? -TW'(sc_sum >> 16) : TW'(sc_sum >> 16);
		sc_new  = acc_ph_q ? (TW'(last_q[i_q]) + sc_res) : sc_res;
		div_ge  = rem_q >= dsh_q;
		div_lim = acc_ph_q ? m_q[30:0] : maxv_q[30:0];
		div_den = acc_ph_q ? b_q : amax_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept && cmd.opcode == OP_TICK) state_d = ST_ROT_MUL;
			ST_ROT_MUL: state_d = ST_ROT_ADD;
			ST_ROT_ADD: state_d = ST_WHL_MUL;
			ST_WHL_MUL: state_d = ST_WHL_WR;
			ST_WHL_WR:  state_d = last_wheel ? ST_VCHK : ST_WHL_MUL;
			ST_VCHK: begin
				if (vel_over)
					state_d = ST_DIV;
				else
					state_d = maxa_q[31] ? ST_FIN : ST_ACC_MUL;
			end
			ST_DIV:     if (cnt_q == 4'd0) state_d = ST_SC_LO;
			ST_SC_LO:   state_d = ST_SC_HI;
			ST_SC_HI:   state_d = ST_SC_WR;
			ST_SC_WR: begin
				if (!last_wheel)
					state_d = ST_SC_LO;
				else if (acc_ph_q || maxa_q[31])
					state_d = ST_FIN;
				else
					state_d = ST_ACC_MUL;
			end
			ST_ACC_MUL: state_d = ST_ACC_LIM;
			ST_ACC_LIM: state_d = ST_BMAX;
			ST_BMAX:    state_d = last_wheel ? ST_BCHK : ST_BMAX;
			ST_BCHK:    state_d = (b_q > TW'(m_q)) ? ST_DIV : ST_FIN;
			ST_FIN:     if (fin_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and handshake
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ROT_MUL: begin
				mul_a = 36'(trot_q);
				mul_b = 24'(rr_q);
			end
			ST_WHL_MUL: begin
				mul_a = lin_s;
				mul_b = iwr_q;
			end
			ST_SC_LO: begin
				mul_a = {12'd0, sc_mag[23:0]};
				mul_b = {8'd0, quo_q};
			end
			ST_SC_HI: begin
				mul_a = {12'd0, sc_mag[47:24]};
				mul_b = {8'd0, quo_q};
			end
			ST_ACC_MUL: begin
				mul_a = 36'(maxa_q);
				mul_b = {8'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= 61'(mul_a * $signed({1'b0, mul_b}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			maxv_q  <= '0;
			maxa_q  <= '0;
			rr_q    <= 18'd16908;
			iwr_q   <= 24'd1310720;
			invm_q  <= '0;
			tx_q    <= '0;
			ty_q    <= '0;
			trot_q  <= '0;
			for (int k = 0; k < 4; k++)
				last_q[k] <= '0;
			out_valid_q <= 1'b0;
			i_q      <= '0;
			acc_ph_q <= 1'b0;
			vlim_q   <= 1'b0;
			alim_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_VEL: maxv_q <= cfg_data;
					REG_MAX_ACC: maxa_q <= cfg_data;
					REG_ROBOT_R: rr_q   <= cfg_data[17:0];
					REG_INV_WR:  iwr_q  <= cfg_data[23:0];
					REG_INVERT:  invm_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.opcode == OP_SET) begin
							tx_q   <= invm_q[0] ? neg_sat(cmd.vel_x) : cmd.vel_x;
							ty_q   <= invm_q[1] ? neg_sat(cmd.vel_y) : cmd.vel_y;
							trot_q <= invm_q[2] ? neg_sat(cmd.rot_z) : cmd.rot_z;
						end else begin
							dt_q     <= cmd.elapsed_time;
							amax_q   <= '0;
							i_q      <= '0;
							acc_ph_q <= 1'b0;
							vlim_q   <= 1'b0;
							alim_q   <= 1'b0;
						end
					end
				end
				ST_ROT_ADD: r_q <= rot_r[34:0];
				ST_WHL_WR: begin
					t_q[i_q] <= wheel_t[TW-1:0];
					if (wt_mag > amax_q)
						amax_q <= wt_mag;
					i_q <= i_q + 2'd1;
				end
				ST_VCHK: begin
					if (vel_over) begin
						rem_q  <= {17'd0, div_lim, 16'd0};
						dsh_q  <= {1'b0, div_den, 15'd0};
						quo_q  <= '0;
						cnt_q  <= 4'd15;
						vlim_q <= 1'b1;
					end
					i_q <= '0;
				end
				ST_DIV: begin
					// one quotient bit per cycle, largest first
					if (div_ge)
						rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[14:0], div_ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 4'd1;
				end
				ST_SC_HI: lo_q <= prod_q[39:0];
				ST_SC_WR: begin
					t_q[i_q] <= sc_new;
					i_q <= i_q + 2'd1;
				end
				ST_ACC_LIM: begin
					m_q      <= prod_q[47:16];
					b_q      <= '0;
					i_q      <= '0;
					acc_ph_q <= 1'b1;
				end
				ST_BMAX: begin
					if (sc_mag > b_q)
						b_q <= sc_mag;
					i_q <= i_q + 2'd1;
				end
				ST_BCHK: begin
					if (b_q > TW'(m_q)) begin
						rem_q  <= {17'd0, div_lim, 16'd0};
						dsh_q  <= {1'b0, div_den, 15'd0};
						quo_q  <= '0;
						cnt_q  <= 4'd15;
						alim_q <= 1'b1;
					end
					i_q <= '0;
				end
				ST_FIN: begin
					if (fin_load) begin
						for (int k = 0; k < 4; k++) begin
							last_q[k] <= sat32(t_q[k]);
							ws_q[k]   <= sat32(t_q[k]);
						end
						ovl_q <= vlim_q;
						oal_q <= alim_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.wheel_speed_0    = ws_q[0];
	assign rsp.wheel_speed_1    = ws_q[1];
	assign rsp.wheel_speed_2    = ws_q[2];
	assign rsp.wheel_speed_3    = ws_q[3];
	assign rsp.velocity_limited = ovl_q;
	assign rsp.accel_limited    = oal_q;

	`OWSL_ASSERT_IMP(a_busy_blocks_cmd, state_q != ST_IDLE, !cmd.ready)
	`OWSL_ASSERT_NXT(a_tick_starts, accept && cmd.opcode == OP_TICK, state_q == ST_ROT_MUL)
	`OWSL_ASSERT_IMP(a_vlim_enabled, rsp.valid && rsp.velocity_limited, !maxv_q[31])
	`OWSL_ASSERT_IMP(a_alim_enabled, rsp.valid && rsp.accel_limited, !maxa_q[31])

endmodule

FILE: tb/sv/tb_omni_wheel_speed_limiter_core.sv
// Self-checking testbench of the omni wheel speed limiter core
module tb_omni_wheel_speed_limiter_core;
	import owsl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 120;
	localparam int LONG_HOLD = 600;

	typedef struct {
		logic               opcode;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] rot_z;
		logic        [15:0] elapsed_time;
	} cmd_item_t;

	typedef struct {
		logic signed [31:0] speed [4];
		logic               vel_lim;
		logic               acc_lim;
	} wheel_cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	owsl_cmd_if cmd ();
	owsl_rsp_if rsp ();

	omni_wheel_speed_limiter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.rsp(rsp)
	);

	cmd_item_t  pending [$];
	wheel_cmd_t speeds_due [$];
	int mismatches;
	bit quiet;
	bit long_hold_req;
	bit long_hold_done;
	bit cmd_taken;
	int src_gap;
	int snk_gap;
	int hold_cnt;

	// mirror of the block's registers and state
	longint lim_vel, lim_acc, robot_r, inv_wr;
	logic [2:0] inv_mask;
	longint tgt_x, tgt_y, tgt_rot;
	longint last_speed [4];

	function automatic longint neg_sat(input longint v);
		return (v == -64'sd2147483648) ? 64'sd2147483647 : -v;
	endfunction

	function automatic longint magn(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint scale_q16(input longint v, input longint k);
		longint p;
		p = (magn(v) * k) >>> 16;
		return v < 0 ? -p : p;
	endfunction

	function automatic void predict_wheels(input cmd_item_t it);
		longint r, a, b, k, m, v;
		longint lin [4];
		longint t [4];
		longint d [4];
		wheel_cmd_t res;
		if (it.opcode == OP_SET) begin
			tgt_x = inv_mask[0] ? neg_sat(longint'(it.vel_x)) : longint'(it.vel_x);
			tgt_y = inv_mask[1] ? neg_sat(longint'(it.vel_y)) : longint'(it.vel_y);
			tgt_rot = inv_mask[2] ? neg_sat(longint'(it.rot_z)) : longint'(it.rot_z);
			return;
		end
		r = (tgt_rot * robot_r + 32768) >>> 16;
		lin[0] = tgt_y;
		lin[1] = tgt_x;
		lin[2] = -tgt_y;
		lin[3] = -tgt_x;
		for (int i = 0; i < 4; i++)
			t[i] = (-((lin[i] + r) * inv_wr) + 32768) >>> 16;
		res.vel_lim = 1'b0;
		res.acc_lim = 1'b0;
		if (lim_vel >= 0) begin
			a = 0;
			for (int i = 0; i < 4; i++)
				if (magn(t[i]) > a) a = magn(t[i]);
			if (a > lim_vel) begin
				k = (lim_vel <<< 16) / a;
				for (int i = 0; i < 4; i++)
					t[i] = scale_q16(t[i], k);
				res.vel_lim = 1'b1;
			end
		end
		if (lim_acc >= 0) begin
			m = (lim_acc * longint'(it.elapsed_time)) >>> 16;
			b = 0;
			for (int i = 0; i < 4; i++) begin
				d[i] = t[i] - last_speed[i];
				if (magn(d[i]) > b) b = magn(d[i]);
			end
			if (b > m) begin
				k = (m <<< 16) / b;
				for (int i = 0; i < 4; i++)
					t[i] = last_speed[i] + scale_q16(d[i], k);
				res.acc_lim = 1'b1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			v = t[i];
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			last_speed[i] = v;
			res.speed[i] = v[31:0];
		end
		speeds_due.push_back(res);
	endfunction

	function automatic logic [31:0] pick_vel();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0;
				default: return 32'hffff_ffff;
			endcase
			2, 3, 4, 5: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return 32'hffff_ffff;
			1: return 32'h8000_0000 | $urandom();
			2: return 32'h0;
			3: return 32'h7fff_ffff;
			4: return $urandom();
			default: return $urandom_range(1, 1 << 22);
		endcase
	endfunction

	function automatic void add_item(input logic op, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [15:0] dt);
		cmd_item_t it;
		it.opcode = op;
		it.vel_x = x;
		it.vel_y = y;
		it.rot_z = z;
		it.elapsed_time = dt;
		pending.push_back(it);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MAX_VEL: lim_vel = longint'(signed'(val));
			REG_MAX_ACC: lim_acc = longint'(signed'(val));
			REG_ROBOT_R: robot_r = longint'(val[17:0]);
			REG_INV_WR:  inv_wr = longint'(val[23:0]);
			REG_INVERT:  inv_mask = val[2:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || cmd.valid || speeds_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(input int n);
		logic [15:0] dt;
		for (int i = 0; i < n; i++) begin
			dt = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4096));
			if ($urandom_range(0, 99) < 55)
				add_item(OP_TICK, $urandom(), $urandom(), $urandom(), dt);
			else
				add_item(OP_SET, pick_vel(), pick_vel(), pick_vel(), 16'($urandom()));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	// sender: hold the offered transaction until it is taken
	always @(posedge clk) cmd_taken <= cmd.valid && cmd.ready;

	always @(negedge clk) begin
		cmd_item_t it;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else if (cmd.valid && !cmd_taken) begin
		end else if (src_gap > 0) begin
			cmd.valid <= 1'b0;
			src_gap <= src_gap - 1;
		end else if (pending.size() != 0) begin
			it = pending.pop_front();
			cmd.valid <= 1'b1;
			cmd.opcode <= it.opcode;
			cmd.vel_x <= it.vel_x;
			cmd.vel_y <= it.vel_y;
			cmd.rot_z <= it.rot_z;
			cmd.elapsed_time <= it.elapsed_time;
			if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 17);
		end else begin
			cmd.valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			rsp.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (long_hold_req && !long_hold_done) begin
			rsp.ready <= 1'b0;
			hold_cnt <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else if (snk_gap > 0) begin
			rsp.ready <= 1'b0;
			snk_gap <= snk_gap - 1;
		end else begin
			rsp.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 17);
		end
	end

	always @(posedge clk) begin
		wheel_cmd_t want;
		cmd_item_t it;
		logic signed [31:0] got [4];
		if (arst_n && rsp.valid && rsp.ready) begin
			got[0] = rsp.wheel_speed_0;
			got[1] = rsp.wheel_speed_1;
			got[2] = rsp.wheel_speed_2;
			got[3] = rsp.wheel_speed_3;
			if (speeds_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction at %0t", $time);
			end else begin
				want = speeds_due.pop_front();
				if (got != want.speed || rsp.velocity_limited !== want.vel_lim
						|| rsp.accel_limited !== want.acc_lim) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp %0d %0d %0d %0d v%b a%b, got %0d %0d %0d %0d v%b a%b",
							$time, want.speed[0], want.speed[1], want.speed[2], want.speed[3],
							want.vel_lim, want.acc_lim, got[0], got[1], got[2], got[3],
							rsp.velocity_limited, rsp.accel_limited);
				end
			end
		end
		if (arst_n && cmd.valid && cmd.ready) begin
			it.opcode = cmd.opcode;
			it.vel_x = cmd.vel_x;
			it.vel_y = cmd.vel_y;
			it.rot_z = cmd.rot_z;
			it.elapsed_time = cmd.elapsed_time;
			predict_wheels(it);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd.valid = 1'b0;
		cmd.opcode = OP_SET;
		cmd.vel_x = '0;
		cmd.vel_y = '0;
		cmd.rot_z = '0;
		cmd.elapsed_time = '0;
		rsp.ready = 1'b0;
		mismatches = 0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		long_hold_done = 1'b0;
		src_gap = 0;
		snk_gap = 0;
		hold_cnt = 0;
		lim_vel = 0;
		lim_acc = 0;
		robot_r = 16908;
		inv_wr = 1310720;
		inv_mask = 3'b000;
		tgt_x = 0;
		tgt_y = 0;
		tgt_rot = 0;
		for (int i = 0; i < 4; i++) last_speed[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: zero limits force everything to zero
		add_item(OP_SET, 32'h0001_0000, 32'h0000_8000, 32'h0000_3333, 16'h1234);
		add_item(OP_TICK, 32'hdead_beef, 32'h1234_5678, 32'h8000_0000, 16'hffff);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0);
		wait_idle();

		// limits off, extremes of the target
		write_reg(REG_MAX_VEL, 32'hffff_ffff);
		write_reg(REG_MAX_ACC, 32'h8000_0000);
		add_item(OP_SET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);
		add_item(OP_SET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff);
		add_item(OP_TICK, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h0);
		add_item(OP_SET, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0001);
		wait_idle();

		// negate the most negative value, largest geometry
		write_reg(REG_INVERT, 32'h7);
		write_reg(REG_ROBOT_R, 32'h3_ffff);
		write_reg(REG_INV_WR, 32'hff_ffff);
		add_item(OP_SET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h8000);
		add_item(OP_SET, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000, 16'h0);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0);
		wait_idle();

		// zero limits, one at a time
		write_reg(REG_MAX_VEL, 32'h0);
		write_reg(REG_ROBOT_R, 32'h0);
		write_reg(REG_INV_WR, 32'h0);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);
		wait_idle();
		write_reg(REG_MAX_VEL, 32'h7fff_ffff);
		write_reg(REG_MAX_ACC, 32'h0);
		write_reg(REG_ROBOT_R, 32'd16908);
		write_reg(REG_INV_WR, 32'd1310720);
		write_reg(REG_INVERT, 32'h0);
		add_item(OP_SET, 32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, 16'h0);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);
		add_item(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MAX_VEL, pick_limit());
			write_reg(REG_MAX_ACC, pick_limit());
			case ($urandom_range(0, 3))
				0: write_reg(REG_ROBOT_R, 32'h0);
				1: write_reg(REG_ROBOT_R, 32'h3_ffff);
				default: write_reg(REG_ROBOT_R, $urandom_range(0, 32'h3_ffff));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_INV_WR, 32'h0);
				1: write_reg(REG_INV_WR, 32'hff_ffff);
				default: write_reg(REG_INV_WR, $urandom_range(0, 32'h1f_ffff));
			endcase
			write_reg(REG_INVERT, $urandom_range(0, 7));
			if (ph == 7) quiet = 1'b1;
			if (ph == 2) long_hold_req = 1'b1;
			random_items(130);
			wait_idle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
